[rtl/xdkb_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package xdkb_pkg;

  localparam int BUCKET_COUNT = 256;
  localparam int BUCKET_SLOTS = 8;
  localparam int MAX_CLOSEST  = 16;

  localparam int TABLE_SLOTS = BUCKET_COUNT * BUCKET_SLOTS;

  localparam int ID_W   = 256;
  localparam int WORD_W = 64;
  localparam int TAG_W  = 48;
  localparam int TIME_W = 48;
  localparam int CMD_W  = 3;
  localparam int WANT_W = 5;

  localparam int BKT_W  = (BUCKET_COUNT > 1) ? $clog2(BUCKET_COUNT) : 1;
  localparam int FILL_W = $clog2(BUCKET_SLOTS + 1);
  localparam int TAB_AW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int TOT_W  = $clog2(TABLE_SLOTS + 1);
  localparam int CNT_W  = $clog2(MAX_CLOSEST + 1);
  localparam int LZ_W   = $clog2(ID_W + 1);

  localparam int CHUNK_W  = 16;
  localparam int CHUNKS   = ID_W / CHUNK_W;
  localparam int CHUNK_IW = $clog2(CHUNKS);

  localparam int CFG_REGS = 4;
  localparam int CFG_IW   = 2;
  localparam int CFG_AW   = 5;
  localparam int CFG_DW   = 64;

  localparam logic [CMD_W-1:0] CMD_ADD     = 3'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_FIND    = 3'd2;
  localparam logic [CMD_W-1:0] CMD_CLOSEST = 3'd3;
  localparam logic [CMD_W-1:0] CMD_EVICT   = 3'd4;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [TAG_W-1:0]  tag;
    logic [TIME_W-1:0] seen;
  } rec_t;

  typedef struct packed {
    logic ok;
    logic has;
    logic last;
    rec_t rec;
  } res_t;

  typedef struct packed {
    logic             done;
    logic [BKT_W-1:0] bucket;
  } lz_rsp_t;

  function automatic logic [3:0] lz8(logic [7:0] v);
    logic [3:0] n;
    logic       hit;
    n   = '0;
    hit = 1'b0;
    for (int i = 7; i >= 0; i--) begin
      if (!hit) begin
        if (v[i]) hit = 1'b1;
        else n = n + 4'd1;
      end
    end
    return n;
  endfunction

endpackage

`default_nettype wire

[rtl/xdkb_cfg.sv]
`timescale 1ns / 1ps
`default_nettype none

module xdkb_cfg (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [xdkb_pkg::CFG_AW-1:0]         paddr,
  input  wire logic [xdkb_pkg::CFG_DW-1:0]         pwdata,
  output logic      [xdkb_pkg::CFG_DW-1:0]         prdata,
  output logic                                     pready,
  output logic      [xdkb_pkg::ID_W-1:0]           self_id_o
);

  logic [xdkb_pkg::CFG_DW-1:0] self_q [xdkb_pkg::CFG_REGS];
  logic [xdkb_pkg::CFG_IW-1:0] idx;

  assign idx    = paddr[xdkb_pkg::CFG_AW-1:3];
  assign pready = 1'b1;
  assign prdata = self_q[idx];

  assign self_id_o = {self_q[0], self_q[1], self_q[2], self_q[3]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < xdkb_pkg::CFG_REGS; i++) self_q[i] <= '0;
    end else if (psel && penable && pwrite) begin
      self_q[idx] <= pwdata;
    end
  end

endmodule

`default_nettype wire

[rtl/xdkb_lzc.sv]
`timescale 1ns / 1ps
`default_nettype none

module xdkb_lzc (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [xdkb_pkg::ID_W-1:0]   key_i,
  input  wire logic [xdkb_pkg::ID_W-1:0]   self_i,
  output xdkb_pkg::lz_rsp_t                rsp_o
);

  logic                              busy_q;
  logic                              done_q;
  logic [xdkb_pkg::CHUNK_IW-1:0]     idx_q;
  logic [xdkb_pkg::LZ_W-1:0]         cnt_q;
  logic [xdkb_pkg::ID_W-1:0]         dist_q;
  logic [xdkb_pkg::CHUNK_W-1:0]      chunk;
  logic [4:0]                        chunk_lz;
  logic                              chunk_nz;
  logic                              last_chunk;

  assign chunk      = dist_q[xdkb_pkg::ID_W-1 -: xdkb_pkg::CHUNK_W];
  assign chunk_nz   = chunk != '0;
  assign chunk_lz   = (chunk[15:8] != 8'd0) ? {1'b0, xdkb_pkg::lz8(chunk[15:8])}
                                            : 5'd8 + {1'b0, xdkb_pkg::lz8(chunk[7:0])};
  assign last_chunk = idx_q == xdkb_pkg::CHUNK_IW'(xdkb_pkg::CHUNKS - 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      idx_q  <= '0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        idx_q  <= '0;
        cnt_q  <= '0;
      end else if (busy_q) begin
        idx_q <= idx_q + 1'b1;
        cnt_q <= cnt_q + (chunk_nz ? xdkb_pkg::LZ_W'(chunk_lz)
                                   : xdkb_pkg::LZ_W'(xdkb_pkg::CHUNK_W));
        if (chunk_nz || last_chunk) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) dist_q <= key_i ^ self_i;
    else if (busy_q) dist_q <= dist_q << xdkb_pkg::CHUNK_W;
  end

  assign rsp_o.done   = done_q;
  assign rsp_o.bucket = (cnt_q >= xdkb_pkg::LZ_W'(xdkb_pkg::BUCKET_COUNT - 1))
                        ? xdkb_pkg::BKT_W'(xdkb_pkg::BUCKET_COUNT - 1)
                        : xdkb_pkg::BKT_W'(cnt_q);

endmodule

`default_nettype wire

[rtl/xor_distance_k_bucket_table.sv]
// channel   direction  handshake                 word
// ------------------------------------------------------------------------------
// input     in         in_valid_i / in_stall_o   cmd, key, tag, times, count
// output    out        out_valid_o / out_stall_i one result record
// config    in         psel/penable/pwrite       64-bit own-id words at 8*i
//
// add, remove, find: bucket index found one 16-bit chunk at a time, slots
// searched in turn, later slots moved down on a hit; one slot access at a time
// closest query: each result scans every bucket and every stored node
// stale eviction: one scan of every bucket and every stored node
// reset clears fill valid bits, node count and control; slot memory is not
// cleared; in_stall_o is high after accept until the last word is registered
`timescale 1ns / 1ps
`default_nettype none

module xor_distance_k_bucket_table (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [xdkb_pkg::CFG_AW-1:0]         paddr,
  input  wire logic [xdkb_pkg::CFG_DW-1:0]         pwdata,
  output logic      [xdkb_pkg::CFG_DW-1:0]         prdata,
  output logic                                     pready,
  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire logic [xdkb_pkg::CMD_W-1:0]          cmd_i,
  input  wire logic [xdkb_pkg::WORD_W-1:0]         key_word0_i,
  input  wire logic [xdkb_pkg::WORD_W-1:0]         key_word1_i,
  input  wire logic [xdkb_pkg::WORD_W-1:0]         key_word2_i,
  input  wire logic [xdkb_pkg::WORD_W-1:0]         key_word3_i,
  input  wire logic [xdkb_pkg::TAG_W-1:0]          endpoint_tag_i,
  input  wire logic [xdkb_pkg::TIME_W-1:0]         seen_time_i,
  input  wire logic [xdkb_pkg::TIME_W-1:0]         now_time_i,
  input  wire logic [xdkb_pkg::TIME_W-1:0]         max_age_i,
  input  wire logic [xdkb_pkg::WANT_W-1:0]         want_count_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output logic                                     ok_o,
  output logic                                     has_node_o,
  output logic      [xdkb_pkg::WORD_W-1:0]         out_word0_o,
  output logic      [xdkb_pkg::WORD_W-1:0]         out_word1_o,
  output logic      [xdkb_pkg::WORD_W-1:0]         out_word2_o,
  output logic      [xdkb_pkg::WORD_W-1:0]         out_word3_o,
  output logic      [xdkb_pkg::TAG_W-1:0]          out_endpoint_o,
  output logic      [xdkb_pkg::TIME_W-1:0]         out_seen_o,
  output logic      [xdkb_pkg::TOT_W-1:0]          node_total_o,
  output logic                                     last_o
);

  localparam logic [4:0] S_IDLE     = 5'd0;
  localparam logic [4:0] S_DISPATCH = 5'd1;
  localparam logic [4:0] S_LZ       = 5'd2;
  localparam logic [4:0] S_UFRD     = 5'd3;
  localparam logic [4:0] S_UFILL    = 5'd4;
  localparam logic [4:0] S_SRCH_RD  = 5'd5;
  localparam logic [4:0] S_SRCH_CHK = 5'd6;
  localparam logic [4:0] S_GAP_RD   = 5'd7;
  localparam logic [4:0] S_GAP_WR   = 5'd8;
  localparam logic [4:0] S_CL_ROUND = 5'd9;
  localparam logic [4:0] S_CL_FRD   = 5'd10;
  localparam logic [4:0] S_CL_FILL  = 5'd11;
  localparam logic [4:0] S_CL_SRD   = 5'd12;
  localparam logic [4:0] S_CL_USE   = 5'd13;
  localparam logic [4:0] S_CL_CMP1  = 5'd14;
  localparam logic [4:0] S_CL_CMP2  = 5'd15;
  localparam logic [4:0] S_CL_END   = 5'd16;
  localparam logic [4:0] S_CL_NEXT  = 5'd17;
  localparam logic [4:0] S_EV_FRD   = 5'd18;
  localparam logic [4:0] S_EV_FILL  = 5'd19;
  localparam logic [4:0] S_EV_SRD   = 5'd20;
  localparam logic [4:0] S_EV_USE   = 5'd21;
  localparam logic [4:0] S_EMIT     = 5'd22;

  localparam logic [xdkb_pkg::BKT_W-1:0]  LAST_BKT  = xdkb_pkg::BKT_W'(xdkb_pkg::BUCKET_COUNT - 1);
  localparam logic [xdkb_pkg::FILL_W-1:0] FULL_FILL = xdkb_pkg::FILL_W'(xdkb_pkg::BUCKET_SLOTS);

  logic [4:0]                         state_q;
  logic [xdkb_pkg::ID_W-1:0]          self_id;
  xdkb_pkg::lz_rsp_t                  lz_rsp;
  logic                               lz_start;

  logic [xdkb_pkg::CMD_W-1:0]         cmd_q;
  logic [xdkb_pkg::ID_W-1:0]          key_q;
  xdkb_pkg::rec_t                     keyrec_q;
  logic [xdkb_pkg::TIME_W-1:0]        now_q;
  logic [xdkb_pkg::TIME_W-1:0]        max_q;
  logic [xdkb_pkg::CNT_W-1:0]         want_q;
  logic [xdkb_pkg::CNT_W-1:0]         r_q;
  logic [xdkb_pkg::BKT_W-1:0]         b_q;
  logic [xdkb_pkg::FILL_W-1:0]        s_q;
  logic [xdkb_pkg::FILL_W-1:0]        keep_q;
  logic [xdkb_pkg::FILL_W-1:0]        fill_q;
  logic [xdkb_pkg::TOT_W-1:0]         total_q;
  logic [xdkb_pkg::ID_W-1:0]          d_q;
  logic [xdkb_pkg::ID_W-1:0]          prev_q;
  logic [xdkb_pkg::ID_W-1:0]          bestd_q;
  xdkb_pkg::rec_t                     cand_q;
  xdkb_pkg::rec_t                     best_q;
  xdkb_pkg::rec_t                     pend_q;
  logic                               have_prev_q;
  logic                               have_best_q;
  logic                               have_pend_q;
  xdkb_pkg::res_t                     res_q;
  xdkb_pkg::res_t                     res_fail;

  logic                               out_vld_q;
  xdkb_pkg::res_t                     out_res_q;
  logic [xdkb_pkg::TOT_W-1:0]         out_tot_q;
  logic                               out_free;
  logic                               out_load;

  xdkb_pkg::rec_t                     tab_mem [xdkb_pkg::TABLE_SLOTS];
  xdkb_pkg::rec_t                     tab_rd_q;
  xdkb_pkg::rec_t                     tab_wdata;
  logic                               tab_we;
  logic                               tab_re;
  logic [xdkb_pkg::TAB_AW-1:0]        tab_waddr;
  logic [xdkb_pkg::TAB_AW-1:0]        tab_raddr;

  logic [xdkb_pkg::FILL_W-1:0]        fill_mem [xdkb_pkg::BUCKET_COUNT];
  logic [xdkb_pkg::BUCKET_COUNT-1:0]  fill_vld_q;
  logic [xdkb_pkg::FILL_W-1:0]        fill_rd_q;
  logic                               fill_rd_vld_q;
  logic [xdkb_pkg::FILL_W-1:0]        fill_val;
  logic [xdkb_pkg::FILL_W-1:0]        fill_wdata;
  logic                               fill_we;
  logic                               fill_re;

  logic                               self_hit;
  logic                               cmp_lt;
  logic [xdkb_pkg::TIME_W-1:0]        age;
  logic                               age_ok;
  logic [xdkb_pkg::FILL_W-1:0]        s_inc;

  function automatic logic [xdkb_pkg::TAB_AW-1:0] slot_addr(
    logic [xdkb_pkg::BKT_W-1:0]  b,
    logic [xdkb_pkg::FILL_W-1:0] s
  );
    return xdkb_pkg::TAB_AW'(b) * xdkb_pkg::TAB_AW'(xdkb_pkg::BUCKET_SLOTS)
           + xdkb_pkg::TAB_AW'(s);
  endfunction

  xdkb_cfg u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .self_id_o (self_id)
  );

  xdkb_lzc u_lzc (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (lz_start),
    .key_i   (key_q),
    .self_i  (self_id),
    .rsp_o   (lz_rsp)
  );

  assign self_hit = key_q == self_id;
  assign lz_start = (state_q == S_DISPATCH) &&
                    ((cmd_q == xdkb_pkg::CMD_ADD && !self_hit) ||
                     cmd_q == xdkb_pkg::CMD_REMOVE || cmd_q == xdkb_pkg::CMD_FIND);

  // 256-bit magnitude compare, used in both closest compare states
  assign cmp_lt = (state_q == S_CL_CMP1) ? (prev_q < d_q) : (d_q < bestd_q);

  assign age      = now_q - tab_rd_q.seen;
  assign age_ok   = age <= max_q;
  assign s_inc    = s_q + xdkb_pkg::FILL_W'(1);
  assign fill_val = fill_rd_vld_q ? fill_rd_q : '0;
  assign res_fail = '{ok: 1'b0, has: 1'b0, last: 1'b1, rec: '0};

  assign in_stall_o = state_q != S_IDLE;
  assign out_free   = !out_vld_q || !out_stall_i;
  assign out_load   = (state_q == S_EMIT) && out_free;

  always_comb begin
    tab_re     = 1'b0;
    tab_raddr  = slot_addr(b_q, s_q);
    tab_we     = 1'b0;
    tab_waddr  = slot_addr(b_q, s_q);
    tab_wdata  = tab_rd_q;
    fill_re    = 1'b0;
    fill_we    = 1'b0;
    fill_wdata = fill_q;
    unique case (state_q)
      S_UFRD, S_CL_FRD, S_EV_FRD: begin
        fill_re = 1'b1;
      end
      S_SRCH_RD: begin
        if (s_q == fill_q) begin
          if (cmd_q == xdkb_pkg::CMD_ADD && fill_q < FULL_FILL) begin
            tab_we     = 1'b1;
            tab_waddr  = slot_addr(b_q, fill_q);
            tab_wdata  = keyrec_q;
            fill_we    = 1'b1;
            fill_wdata = fill_q + xdkb_pkg::FILL_W'(1);
          end
        end else begin
          tab_re = 1'b1;
        end
      end
      S_GAP_RD: begin
        if (s_inc < fill_q) begin
          tab_re    = 1'b1;
          tab_raddr = slot_addr(b_q, s_inc);
        end else if (cmd_q == xdkb_pkg::CMD_ADD) begin
          tab_we    = 1'b1;
          tab_waddr = slot_addr(b_q, fill_q - xdkb_pkg::FILL_W'(1));
          tab_wdata = keyrec_q;
        end else begin
          fill_we    = 1'b1;
          fill_wdata = fill_q - xdkb_pkg::FILL_W'(1);
        end
      end
      S_GAP_WR: begin
        tab_we = 1'b1;
      end
      S_CL_SRD: begin
        tab_re = s_q != fill_q;
      end
      S_EV_SRD: begin
        if (s_q != fill_q) begin
          tab_re = 1'b1;
        end else begin
          fill_we    = 1'b1;
          fill_wdata = keep_q;
        end
      end
      S_EV_USE: begin
        if (age_ok && keep_q != s_q) begin
          tab_we    = 1'b1;
          tab_waddr = slot_addr(b_q, keep_q);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (tab_we) tab_mem[tab_waddr] <= tab_wdata;
    if (tab_re) tab_rd_q <= tab_mem[tab_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (fill_we) fill_mem[b_q] <= fill_wdata;
    if (fill_re) fill_rd_q <= fill_mem[b_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_vld_q    <= '0;
      fill_rd_vld_q <= 1'b0;
    end else begin
      if (fill_we) fill_vld_q[b_q] <= 1'b1;
      if (fill_re) fill_rd_vld_q <= fill_vld_q[b_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      total_q     <= '0;
      have_prev_q <= 1'b0;
      have_best_q <= 1'b0;
      have_pend_q <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            cmd_q         <= cmd_i;
            key_q         <= {key_word0_i, key_word1_i, key_word2_i, key_word3_i};
            keyrec_q.id   <= {key_word0_i, key_word1_i, key_word2_i, key_word3_i};
            keyrec_q.tag  <= endpoint_tag_i;
            keyrec_q.seen <= (seen_time_i == '0) ? now_time_i : seen_time_i;
            now_q         <= now_time_i;
            max_q         <= max_age_i;
            want_q        <= (int'(want_count_i) > xdkb_pkg::MAX_CLOSEST)
                             ? xdkb_pkg::CNT_W'(xdkb_pkg::MAX_CLOSEST)
                             : xdkb_pkg::CNT_W'(want_count_i);
            state_q       <= S_DISPATCH;
          end
        end
        S_DISPATCH: begin
          priority if (lz_start) begin
            state_q <= S_LZ;
          end else if (cmd_q == xdkb_pkg::CMD_CLOSEST && want_q != '0) begin
            r_q         <= '0;
            have_prev_q <= 1'b0;
            have_pend_q <= 1'b0;
            state_q     <= S_CL_ROUND;
          end else if (cmd_q == xdkb_pkg::CMD_EVICT) begin
            b_q     <= '0;
            state_q <= S_EV_FRD;
          end else begin
            res_q   <= res_fail;
            state_q <= S_EMIT;
          end
        end
        S_LZ: begin
          if (lz_rsp.done) begin
            b_q     <= lz_rsp.bucket;
            state_q <= S_UFRD;
          end
        end
        S_UFRD: begin
          state_q <= S_UFILL;
        end
        S_UFILL: begin
          fill_q  <= fill_val;
          s_q     <= '0;
          state_q <= S_SRCH_RD;
        end
        S_SRCH_RD: begin
          if (s_q == fill_q) begin
            if (cmd_q == xdkb_pkg::CMD_ADD && fill_q < FULL_FILL) begin
              total_q <= total_q + xdkb_pkg::TOT_W'(1);
              res_q   <= '{ok: 1'b1, has: 1'b0, last: 1'b1, rec: '0};
            end else begin
              res_q <= res_fail;
            end
            state_q <= S_EMIT;
          end else begin
            state_q <= S_SRCH_CHK;
          end
        end
        S_SRCH_CHK: begin
          if (tab_rd_q.id == key_q) begin
            if (cmd_q == xdkb_pkg::CMD_FIND) begin
              res_q   <= '{ok: 1'b1, has: 1'b1, last: 1'b1, rec: tab_rd_q};
              state_q <= S_EMIT;
            end else begin
              state_q <= S_GAP_RD;
            end
          end else begin
            s_q     <= s_inc;
            state_q <= S_SRCH_RD;
          end
        end
        S_GAP_RD: begin
          if (s_inc < fill_q) begin
            state_q <= S_GAP_WR;
          end else begin
            if (cmd_q == xdkb_pkg::CMD_REMOVE) total_q <= total_q - xdkb_pkg::TOT_W'(1);
            res_q   <= '{ok: 1'b1, has: 1'b0, last: 1'b1, rec: '0};
            state_q <= S_EMIT;
          end
        end
        S_GAP_WR: begin
          s_q     <= s_inc;
          state_q <= S_GAP_RD;
        end
        S_CL_ROUND: begin
          b_q         <= '0;
          have_best_q <= 1'b0;
          state_q     <= S_CL_FRD;
        end
        S_CL_FRD: begin
          state_q <= S_CL_FILL;
        end
        S_CL_FILL: begin
          fill_q  <= fill_val;
          s_q     <= '0;
          state_q <= S_CL_SRD;
        end
        S_CL_SRD: begin
          if (s_q == fill_q) begin
            if (b_q == LAST_BKT) begin
              state_q <= S_CL_END;
            end else begin
              b_q     <= b_q + 1'b1;
              state_q <= S_CL_FRD;
            end
          end else begin
            state_q <= S_CL_USE;
          end
        end
        S_CL_USE: begin
          d_q     <= tab_rd_q.id ^ key_q;
          cand_q  <= tab_rd_q;
          state_q <= S_CL_CMP1;
        end
        S_CL_CMP1: begin
          if (!have_prev_q || cmp_lt) begin
            state_q <= S_CL_CMP2;
          end else begin
            s_q     <= s_inc;
            state_q <= S_CL_SRD;
          end
        end
        S_CL_CMP2: begin
          if (!have_best_q || cmp_lt) begin
            bestd_q     <= d_q;
            best_q      <= cand_q;
            have_best_q <= 1'b1;
          end
          s_q     <= s_inc;
          state_q <= S_CL_SRD;
        end
        S_CL_END: begin
          if (have_best_q) begin
            prev_q      <= bestd_q;
            have_prev_q <= 1'b1;
            r_q         <= r_q + 1'b1;
            pend_q      <= best_q;
            have_pend_q <= 1'b1;
            if (have_pend_q) begin
              res_q   <= '{ok: 1'b1, has: 1'b1, last: 1'b0, rec: pend_q};
              state_q <= S_EMIT;
            end else begin
              state_q <= S_CL_NEXT;
            end
          end else begin
            res_q   <= have_pend_q ? '{ok: 1'b1, has: 1'b1, last: 1'b1, rec: pend_q}
                                   : res_fail;
            state_q <= S_EMIT;
          end
        end
        S_CL_NEXT: begin
          if (r_q == want_q) begin
            res_q   <= '{ok: 1'b1, has: 1'b1, last: 1'b1, rec: pend_q};
            state_q <= S_EMIT;
          end else begin
            state_q <= S_CL_ROUND;
          end
        end
        S_EV_FRD: begin
          state_q <= S_EV_FILL;
        end
        S_EV_FILL: begin
          fill_q  <= fill_val;
          s_q     <= '0;
          keep_q  <= '0;
          state_q <= S_EV_SRD;
        end
        S_EV_SRD: begin
          if (s_q == fill_q) begin
            total_q <= total_q - xdkb_pkg::TOT_W'(fill_q - keep_q);
            if (b_q == LAST_BKT) begin
              res_q   <= '{ok: 1'b1, has: 1'b0, last: 1'b1, rec: '0};
              state_q <= S_EMIT;
            end else begin
              b_q     <= b_q + 1'b1;
              state_q <= S_EV_FRD;
            end
          end else begin
            state_q <= S_EV_USE;
          end
        end
        S_EV_USE: begin
          if (age_ok) keep_q <= keep_q + xdkb_pkg::FILL_W'(1);
          s_q     <= s_inc;
          state_q <= S_EV_SRD;
        end
        S_EMIT: begin
          if (out_free) state_q <= res_q.last ? S_IDLE : S_CL_NEXT;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_load) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_res_q <= res_q;
      out_tot_q <= total_q;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign ok_o           = out_res_q.ok;
  assign has_node_o     = out_res_q.has;
  assign last_o         = out_res_q.last;
  assign out_word0_o    = out_res_q.rec.id[255:192];
  assign out_word1_o    = out_res_q.rec.id[191:128];
  assign out_word2_o    = out_res_q.rec.id[127:64];
  assign out_word3_o    = out_res_q.rec.id[63:0];
  assign out_endpoint_o = out_res_q.rec.tag;
  assign out_seen_o     = out_res_q.rec.seen;
  assign node_total_o   = out_tot_q;

`ifndef NO_ASSERTIONS
  a_total_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= xdkb_pkg::TOT_W'(xdkb_pkg::TABLE_SLOTS))
    else $error("node count above table size");

  a_port_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(tab_we && tab_re))
    else $error("slot memory read and write in one cycle");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_UFILL || state_q == S_CL_FILL || state_q == S_EV_FILL)
      |-> fill_val <= FULL_FILL)
    else $error("bucket fill above slot count");

  a_emit_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> out_vld_q && (state_q != S_EMIT || !$past(res_q.last)))
    else $error("word not presented after load");
`endif

endmodule

`default_nettype wire
